FILE: rtl/sitd_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`default_nettype none
package sitd_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int CHAR_WIDTH = 8;
	localparam int BCD_WIDTH = 4;

	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'd48;
	localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;
	localparam logic [BCD_WIDTH-1:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [BCD_WIDTH-1:0] BCD_ADJ = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	typedef struct packed {
		logic clear;
		logic conv;
		logic shift;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/sitd_value_if.sv
// Input channel carrying one signed integer per item.
`default_nettype none
interface sitd_value_if #(
	parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/sitd_char_if.sv
// Output channel carrying one ASCII character per item.
`default_nettype none
interface sitd_char_if;
	logic valid;
	logic ready;
	logic [sitd_pkg::CHAR_WIDTH-1:0] char_code;
	logic last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, most significant character first.
// One item is taken at a time. The magnitude is shifted into a row of BCD digit cells one
// bit per cycle; the same row then shifts toward its top cell, dropping leading zeros
// silently and presenting each remaining digit as one item, after a '-' item for a
// negative value. The row holds NDIG cells, NDIG being the digit count of
// 2^(VALUE_WIDTH-1). The final character carries last; a new value is taken the cycle
// after it is delivered.
`default_nettype none
module signed_int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sitd_value_if.sink  number,
	sitd_char_if.source text
);
	localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int DIG_W = $clog2(NDIG + 1);
	localparam int BW = sitd_pkg::BCD_WIDTH;

	sitd_pkg::state_t state_q, state_d;
	sitd_pkg::cell_ctl_t ctl;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       bit_cnt_q;
	logic [DIG_W-1:0]       dig_cnt_q;
	logic                   seen_q;

	logic [BW-1:0] digit [NDIG];
	logic          carry [NDIG];
	logic          cell_bit [NDIG];
	logic [BW-1:0] top;
	logic          accept_in;
	logic          skip;
	logic          emit;
	logic          final_dig;

	assign top = digit[NDIG-1];
	assign accept_in = number.valid && number.ready;
	assign final_dig = (dig_cnt_q == DIG_W'(1));

	genvar gi;
	generate
		for (gi = 0; gi < NDIG; gi++) begin : g_cell
			logic [BW-1:0] shift_in;
			if (gi == 0) begin : g_first
				assign cell_bit[gi] = mag_q[VALUE_WIDTH-1];
				assign shift_in = '0;
			end else begin : g_rest
				assign cell_bit[gi] = carry[gi-1];
				assign shift_in = digit[gi-1];
			end
			sitd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.bit_in   (cell_bit[gi]),
				.digit_in (shift_in),
				.digit    (digit[gi]),
				.carry    (carry[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		number.ready = 1'b0;
		text.valid = 1'b0;
		text.char_code = sitd_pkg::CHAR_ZERO + {{(sitd_pkg::CHAR_WIDTH - BW){1'b0}}, top};
		text.last = 1'b0;
		skip = 1'b0;
		emit = 1'b0;
		case (state_q)
			sitd_pkg::ST_IDLE: begin
				number.ready = 1'b1;
				if (number.valid) begin
					ctl.clear = 1'b1;
					state_d = sitd_pkg::ST_CONV;
				end
			end
			sitd_pkg::ST_CONV: begin
				ctl.conv = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = neg_q ? sitd_pkg::ST_SIGN : sitd_pkg::ST_DIGITS;
				end
			end
			sitd_pkg::ST_SIGN: begin
				text.valid = 1'b1;
				text.char_code = sitd_pkg::CHAR_MINUS;
				if (text.ready) begin
					state_d = sitd_pkg::ST_DIGITS;
				end
			end
			sitd_pkg::ST_DIGITS: begin
				if (!seen_q && top == '0 && !final_dig) begin
					skip = 1'b1;
					ctl.shift = 1'b1;
				end else begin
					text.valid = 1'b1;
					text.last = final_dig;
					if (text.ready) begin
						emit = 1'b1;
						ctl.shift = 1'b1;
						if (final_dig) begin
							state_d = sitd_pkg::ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = sitd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			seen_q <= 1'b0;
		end else begin
			if (accept_in) begin
				neg_q <= number.value[VALUE_WIDTH-1];
				bit_cnt_q <= CNT_W'(VALUE_WIDTH - 1);
				dig_cnt_q <= DIG_W'(NDIG);
				seen_q <= 1'b0;
			end else if (ctl.conv) begin
				bit_cnt_q <= bit_cnt_q - CNT_W'(1);
			end else if (skip || emit) begin
				dig_cnt_q <= dig_cnt_q - DIG_W'(1);
				seen_q <= seen_q | emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			mag_q <= number.value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-number.value)
				: VALUE_WIDTH'(number.value);
		end else if (ctl.conv) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/sitd_cell.sv
// One BCD digit cell of the shift-and-add-3 chain, also a stage of the output shift line.
`default_nettype none
module sitd_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sitd_pkg::cell_ctl_t            ctl,
	input  wire logic                           bit_in,
	input  wire logic [sitd_pkg::BCD_WIDTH-1:0] digit_in,
	output logic [sitd_pkg::BCD_WIDTH-1:0]      digit,
	output logic                                carry
);
	logic [sitd_pkg::BCD_WIDTH-1:0] digit_q;
	logic [sitd_pkg::BCD_WIDTH-1:0] adj;

	assign adj = (digit_q >= sitd_pkg::BCD_ADJ_MIN) ? digit_q + sitd_pkg::BCD_ADJ : digit_q;
	assign carry = adj[sitd_pkg::BCD_WIDTH-1];
	assign digit = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.conv) begin
			digit_q <= {adj[sitd_pkg::BCD_WIDTH-2:0], bit_in};
		end else if (ctl.shift) begin
			digit_q <= digit_in;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/sitd_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
`default_nettype none
module sitd_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [sitd_pkg::CHAR_WIDTH-1:0]   out_char,
	input wire logic                              out_last
);
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after an item was taken");

	a_no_text_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("character shown before conversion finished");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while text is being delivered");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
		else $error("block not idle after final character");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
		else $error("stalled character changed");
endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (number.valid),
	.in_ready  (number.ready),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.out_char  (text.char_code),
	.out_last  (text.last)
);
`default_nettype wire
